/* rtl/ymodem_data_frame_receiver_defines.svh */
// assertion macros for the ymodem data frame receiver
`ifndef YMODEM_DATA_FRAME_RECEIVER_DEFINES_SVH
`define YMODEM_DATA_FRAME_RECEIVER_DEFINES_SVH
`ifndef SYNTH
`define YDFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ydfr check failed");
`define YDFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ydfr check failed");
`else
`define YDFR_ASSERT_IMP(lbl, ante, cons)
`define YDFR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/ydfr_pkg.sv */
// types and constants shared by the ymodem data frame receiver
`timescale 1ns / 1ps
package ydfr_pkg;

  localparam int unsigned POS_W   = 11;
  localparam int unsigned OFS_W   = 24;
  localparam int unsigned TOT_W   = 25;

  localparam logic [7:0]       HDR_SHORT  = 8'h01;
  localparam logic [15:0]      CRC_POLY   = 16'h1021;
  localparam logic [15:0]      CRC_INIT   = 16'h0000;
  localparam logic [POS_W-1:0] SHORT_LEN  = 11'd128;
  localparam logic [POS_W-1:0] LONG_LEN   = 11'd1024;
  localparam logic [POS_W-1:0] HDR_LEN    = 11'd3;
  localparam logic [POS_W-1:0] FRAME_OVH  = 11'd5;
  localparam logic [POS_W-1:0] POS_BLK    = 11'd1;
  localparam logic [POS_W-1:0] POS_CMP    = 11'd2;
  localparam logic [TOT_W-1:0] TOTAL_MAX  = 25'h1FF_FFFF;
  localparam logic [7:0]       PAD_MAX    = 8'hFF;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_NEW  = 1'b1;

  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_SHORT = 2'd1,
    VERDICT_CMP   = 2'd2,
    VERDICT_CRC   = 2'd3
  } verdict_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic             result_kind;
    logic [7:0]       payload_byte;
    logic [OFS_W-1:0] byte_offset;
    logic [1:0]       verdict;
    logic [7:0]       block_number;
    logic [7:0]       pad_count;
    logic [TOT_W-1:0] bytes_accepted;
    logic             transfer_complete;
  } out_beat_t;

  // handshake between the stages
  typedef struct packed {
    logic vld;
    logic rdy;
  } stage_ctl_t;

  // crc-16 xmodem, one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/ydfr_in_stage.sv */
// input register of the ymodem data frame receiver
`timescale 1ns / 1ps
module ydfr_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ydfr_pkg::in_beat_t  in_beat,
  input  logic                dn_rdy,
  output ydfr_pkg::stage_ctl_t ctl,
  output ydfr_pkg::in_beat_t  beat
);
  import ydfr_pkg::*;

  logic     vld_r;
  in_beat_t beat_r;

  // holds while the result register cannot take the next beat
  assign in_stall = vld_r && !dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat_r <= in_beat;
    end
  end

  assign ctl.vld = vld_r;
  assign ctl.rdy = dn_rdy;
  assign beat    = beat_r;

endmodule

/* rtl/ydfr_frame_chk.sv */
// frame state, crc check and verdict logic
`timescale 1ns / 1ps
`include "ymodem_data_frame_receiver_defines.svh"
module ydfr_frame_chk #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ydfr_pkg::OFS_W-1:0]     cfg_wdata,
  input  ydfr_pkg::stage_ctl_t           ctl,
  input  ydfr_pkg::in_beat_t             beat,
  output logic                           res_vld,
  output ydfr_pkg::out_beat_t            res
);
  import ydfr_pkg::*;

  localparam int unsigned REM_W = $clog2(PAGE_BYTES);
  localparam int unsigned PAD_W = ($clog2(PAGE_BYTES + 1) > 8) ? $clog2(PAGE_BYTES + 1) : 9;
  localparam logic [REM_W-1:0] REM_LAST = REM_W'(PAGE_BYTES - 1);

  logic                step;
  logic [OFS_W-1:0]    fsize_r;
  logic [POS_W-1:0]    pos_r,  pos_nxt;
  logic                short_r, short_nxt;
  logic [7:0]          blk_r,  blk_nxt;
  logic                cmp_r,  cmp_nxt;
  logic [15:0]         crc_r,  crc_nxt;
  logic [7:0]          th_r,   th_nxt;
  logic                cm_r,   cm_nxt;
  logic [OFS_W-1:0]    tent_r, tent_nxt;
  logic [OFS_W-1:0]    comm_r, comm_nxt;
  logic [TOT_W-1:0]    tot_r,  tot_nxt;
  logic [REM_W-1:0]    trem_r, trem_nxt;
  logic [REM_W-1:0]    crem_r, crem_nxt;

  logic                hdr_short;
  logic [POS_W-1:0]    plen, pay_end, req, p_inc;
  logic                in_pay, emit_pay;
  logic [TOT_W:0]      tot_sum;
  logic [PAD_W-1:0]    pad_full;
  verdict_t            vd;

  assign step = ctl.vld && ctl.rdy;

  always_comb begin
    pos_nxt   = pos_r;
    short_nxt = short_r;
    blk_nxt   = blk_r;
    cmp_nxt   = cmp_r;
    crc_nxt   = crc_r;
    th_nxt    = th_r;
    cm_nxt    = cm_r;
    tent_nxt  = tent_r;
    comm_nxt  = comm_r;
    tot_nxt   = tot_r;
    trem_nxt  = trem_r;
    crem_nxt  = crem_r;
    res_vld   = 1'b0;
    res       = '0;
    vd        = VERDICT_OK;
    tot_sum   = '0;
    pad_full  = '0;

    hdr_short = (pos_r == '0) ? (beat.in_byte == HDR_SHORT) : short_r;
    plen      = hdr_short ? SHORT_LEN : LONG_LEN;
    pay_end   = plen + HDR_LEN;
    req       = plen + FRAME_OVH;
    in_pay    = (pos_r >= HDR_LEN) && (pos_r < pay_end);
    emit_pay  = in_pay && !beat.last_byte && (tent_r < fsize_r);
    p_inc     = (pos_r < req) ? pos_r + POS_W'(1) : pos_r;

    if (step) begin
      if (beat.kind == KIND_NEW) begin
        pos_nxt   = '0;
        short_nxt = 1'b0;
        blk_nxt   = '0;
        cmp_nxt   = 1'b0;
        crc_nxt   = CRC_INIT;
        th_nxt    = '0;
        cm_nxt    = 1'b0;
        tent_nxt  = '0;
        comm_nxt  = '0;
        tot_nxt   = '0;
        trem_nxt  = '0;
        crem_nxt  = '0;
      end else begin
        short_nxt = hdr_short;
        pos_nxt   = p_inc;
        if (pos_r == POS_BLK) begin
          blk_nxt = beat.in_byte;
        end
        if (pos_r == POS_CMP) begin
          cmp_nxt = (blk_r == ~beat.in_byte);
        end
        if (in_pay) begin
          crc_nxt = crc_byte(crc_r, beat.in_byte);
        end
        if (pos_r == pay_end) begin
          th_nxt = beat.in_byte;
        end
        if (pos_r == pay_end + POS_W'(1)) begin
          cm_nxt = ({th_r, beat.in_byte} == crc_r);
        end

        if (emit_pay) begin
          tent_nxt         = tent_r + OFS_W'(1);
          trem_nxt         = (trem_r == REM_LAST) ? '0 : trem_r + REM_W'(1);
          res_vld          = 1'b1;
          res.result_kind  = RES_PAYLOAD;
          res.payload_byte = beat.in_byte;
          res.byte_offset  = tent_r;
        end else if (beat.last_byte) begin
          priority if (p_inc < req) begin
            vd = VERDICT_SHORT;
          end else if (!cmp_nxt) begin
            vd = VERDICT_CMP;
          end else if (!cm_nxt) begin
            vd = VERDICT_CRC;
          end else begin
            vd = VERDICT_OK;
          end

          if (vd == VERDICT_OK) begin
            comm_nxt = tent_r;
            crem_nxt = trem_r;
            tot_sum  = {1'b0, tot_r} + (TOT_W + 1)'(plen);
            tot_nxt  = tot_sum[TOT_W] ? TOTAL_MAX : tot_sum[TOT_W-1:0];
            pad_full = PAD_W'(PAGE_BYTES) - PAD_W'(trem_r);
            if ((tent_r == fsize_r) && (trem_r != '0)) begin
              res.pad_count = (pad_full > PAD_W'(PAD_MAX)) ? PAD_MAX : pad_full[7:0];
            end
          end

          res_vld               = 1'b1;
          res.result_kind       = RES_VERDICT;
          res.byte_offset       = comm_nxt;
          res.verdict           = vd;
          res.block_number      = blk_nxt;
          res.bytes_accepted    = tot_nxt;
          res.transfer_complete = (tot_nxt >= {1'b0, fsize_r});

          // frame done, start over
          pos_nxt   = '0;
          short_nxt = 1'b0;
          blk_nxt   = '0;
          cmp_nxt   = 1'b0;
          crc_nxt   = CRC_INIT;
          th_nxt    = '0;
          cm_nxt    = 1'b0;
          tent_nxt  = comm_nxt;
          trem_nxt  = crem_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsize_r <= '0;
      pos_r   <= '0;
      short_r <= 1'b0;
      blk_r   <= '0;
      cmp_r   <= 1'b0;
      crc_r   <= CRC_INIT;
      th_r    <= '0;
      cm_r    <= 1'b0;
      tent_r  <= '0;
      comm_r  <= '0;
      tot_r   <= '0;
      trem_r  <= '0;
      crem_r  <= '0;
    end else begin
      if (cfg_we) begin
        fsize_r <= cfg_wdata;
      end
      pos_r   <= pos_nxt;
      short_r <= short_nxt;
      blk_r   <= blk_nxt;
      cmp_r   <= cmp_nxt;
      crc_r   <= crc_nxt;
      th_r    <= th_nxt;
      cm_r    <= cm_nxt;
      tent_r  <= tent_nxt;
      comm_r  <= comm_nxt;
      tot_r   <= tot_nxt;
      trem_r  <= trem_nxt;
      crem_r  <= crem_nxt;
    end
  end

  `YDFR_ASSERT_NXT(a_pos_clear, step && (beat.kind == KIND_BYTE) && beat.last_byte, pos_r == '0)
  `YDFR_ASSERT_IMP(a_pos_bound, 1'b1, pos_r <= (LONG_LEN + FRAME_OVH))
  `YDFR_ASSERT_IMP(a_tent_ahead, 1'b1, tent_r >= comm_r)

endmodule

/* rtl/ydfr_out_stage.sv */
// result register of the ymodem data frame receiver
`timescale 1ns / 1ps
module ydfr_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ydfr_pkg::stage_ctl_t ctl,
  input  logic                 res_vld,
  input  ydfr_pkg::out_beat_t  res,
  output logic                 dn_rdy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ydfr_pkg::out_beat_t  out_beat
);
  import ydfr_pkg::*;

  logic      vld_r;
  out_beat_t beat_r;
  logic      load;

  assign dn_rdy = !vld_r || !out_stall;
  assign load   = ctl.vld && dn_rdy && res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (dn_rdy) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_beat  = beat_r;

endmodule

/* rtl/ymodem_data_frame_receiver.sv */
// top level of the ymodem data frame receiver
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | in_valid / in_stall  | in_beat (kind, byte, last)
//  result   | out_valid / out_stall| out_beat (payload/verdict)
//  config   | cfg_we               | cfg_wdata (file size)
//
// one beat per cycle while out_stall is low; each beat is held in the input
// register and its result, if any, is loaded into the result register
// crc, position and offsets update in the single logic stage between the two
// a stalled result register holds the input register, which then stalls
// synchronous active-low reset clears all frame, offset and total state
`timescale 1ns / 1ps
module ymodem_data_frame_receiver #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ydfr_pkg::in_beat_t          in_beat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ydfr_pkg::out_beat_t         out_beat,
  input  logic                        cfg_we,
  input  logic [ydfr_pkg::OFS_W-1:0]  cfg_wdata
);
  import ydfr_pkg::*;

  stage_ctl_t ctl;
  in_beat_t   beat;
  logic       dn_rdy;
  logic       res_vld;
  out_beat_t  res;

  ydfr_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .dn_rdy   (dn_rdy),
    .ctl      (ctl),
    .beat     (beat)
  );

  ydfr_frame_chk #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .beat      (beat),
    .res_vld   (res_vld),
    .res       (res)
  );

  ydfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res_vld   (res_vld),
    .res       (res),
    .dn_rdy    (dn_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

/* verif/ydfr_frame_checker.sv */
// frame checker for the ymodem data frame receiver: predicts every result beat and compares it
`timescale 1ns / 1ps
package ydfr_tb_pkg;

  // crc-16 xmodem, one bit of the byte per step, msb first
  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0} ^ (fb ? ydfr_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

module ydfr_frame_checker #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  ydfr_pkg::in_beat_t          in_beat,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  ydfr_pkg::out_beat_t         out_beat,
  input  logic                        cfg_we,
  input  logic [ydfr_pkg::OFS_W-1:0]  cfg_wdata,
  output int                          mismatches,
  output int                          pending,
  output int                          payloads_seen,
  output int                          frames_ok,
  output int                          frames_rejected
);
  import ydfr_pkg::*;
  import ydfr_tb_pkg::*;

  out_beat_t due_results[$];

  logic [OFS_W-1:0] image_size;
  logic [POS_W-1:0] frame_pos;
  logic             short_hdr;
  logic [7:0]       blk_seen;
  logic             cmp_ok;
  logic [15:0]      crc_acc;
  logic [7:0]       trailer_hi;
  logic             crc_ok;
  logic [OFS_W-1:0] tent_ofs;
  logic [OFS_W-1:0] commit_ofs;
  logic [TOT_W-1:0] accepted_total;

  task automatic drop_frame();
    frame_pos  = '0;
    short_hdr  = 1'b0;
    blk_seen   = '0;
    cmp_ok     = 1'b0;
    crc_acc    = CRC_INIT;
    trailer_hi = '0;
    crc_ok     = 1'b0;
    tent_ofs   = commit_ofs;
  endtask

  // advances the frame state by one byte and queues the beat it should cause
  task automatic predict_frame_byte(input in_beat_t b);
    out_beat_t        r;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] plen;
    logic [POS_W-1:0] need;
    logic [TOT_W:0]   sum;
    int unsigned      rem;
    int unsigned      fill;
    verdict_t         v;
    logic [7:0]       pad;
    if (b.kind == KIND_NEW) begin
      commit_ofs     = '0;
      accepted_total = '0;
      drop_frame();
      return;
    end
    pos = frame_pos;
    if (pos == '0) short_hdr = (b.in_byte == HDR_SHORT);
    plen = short_hdr ? SHORT_LEN : LONG_LEN;
    need = plen + FRAME_OVH;
    r = '0;
    if (pos == POS_BLK) begin
      blk_seen = b.in_byte;
    end else if (pos == POS_CMP) begin
      cmp_ok = (blk_seen == ~b.in_byte);
    end else if (pos >= HDR_LEN && pos < HDR_LEN + plen) begin
      crc_acc = crc16_next(crc_acc, b.in_byte);
      // a payload byte on the flagged last beat only feeds the crc
      if (!b.last_byte && tent_ofs < image_size) begin
        r.result_kind  = RES_PAYLOAD;
        r.payload_byte = b.in_byte;
        r.byte_offset  = tent_ofs;
        due_results.push_back(r);
        tent_ofs++;
        frame_pos = pos + POS_W'(1);
        return;
      end
    end else if (pos == HDR_LEN + plen) begin
      trailer_hi = b.in_byte;
    end else if (pos == HDR_LEN + plen + POS_W'(1)) begin
      crc_ok = ({trailer_hi, b.in_byte} == crc_acc);
    end
    // bytes past the trailer park the position at the frame length
    if (pos < need) pos++;
    frame_pos = pos;
    if (!b.last_byte) return;

    if (pos < need) v = VERDICT_SHORT;
    else if (!cmp_ok) v = VERDICT_CMP;
    else if (!crc_ok) v = VERDICT_CRC;
    else v = VERDICT_OK;

    pad = '0;
    if (v == VERDICT_OK) begin
      commit_ofs     = tent_ofs;
      sum            = {1'b0, accepted_total} + (TOT_W + 1)'(plen);
      accepted_total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOT_W-1:0];
      rem            = 32'(commit_ofs) % PAGE_BYTES;
      if (commit_ofs == image_size && rem != 0) begin
        fill = PAGE_BYTES - rem;
        pad  = (fill > 255) ? PAD_MAX : fill[7:0];
      end
    end
    r.result_kind       = RES_VERDICT;
    r.byte_offset       = commit_ofs;
    r.verdict           = v;
    r.block_number      = blk_seen;
    r.pad_count         = pad;
    r.bytes_accepted    = accepted_total;
    r.transfer_complete = (accepted_total >= {1'b0, image_size});
    due_results.push_back(r);
    drop_frame();
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (got.result_kind === RES_VERDICT) begin
      if (got.verdict === VERDICT_OK) frames_ok++;
      else frames_rejected++;
    end else begin
      payloads_seen++;
    end
    if (due_results.size() == 0) begin
      report("result beat with nothing due", 32'(got.result_kind), 32'h0);
      return;
    end
    want = due_results.pop_front();
    if (got.result_kind !== want.result_kind)
      report("result_kind", 32'(got.result_kind), 32'(want.result_kind));
    if (got.payload_byte !== want.payload_byte)
      report("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
    if (got.byte_offset !== want.byte_offset)
      report("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset));
    if (got.verdict !== want.verdict)
      report("verdict", 32'(got.verdict), 32'(want.verdict));
    if (got.block_number !== want.block_number)
      report("block_number", 32'(got.block_number), 32'(want.block_number));
    if (got.pad_count !== want.pad_count)
      report("pad_count", 32'(got.pad_count), 32'(want.pad_count));
    if (got.bytes_accepted !== want.bytes_accepted)
      report("bytes_accepted", 32'(got.bytes_accepted), 32'(want.bytes_accepted));
    if (got.transfer_complete !== want.transfer_complete)
      report("transfer_complete", 32'(got.transfer_complete), 32'(want.transfer_complete));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      image_size      = '0;
      commit_ofs      = '0;
      accepted_total  = '0;
      drop_frame();
      due_results.delete();
      mismatches      = 0;
      payloads_seen   = 0;
      frames_ok       = 0;
      frames_rejected = 0;
    end else begin
      // the result beat leaving now belongs to an earlier input beat
      if (out_valid && !out_stall) check_result(out_beat);
      if (cfg_we) image_size = cfg_wdata;
      if (in_valid && !in_stall) predict_frame_byte(in_beat);
    end
    pending <= due_results.size();
  end

endmodule

/* verif/tb_ymodem_data_frame_receiver.sv */
// testbench top for the ymodem data frame receiver: frame stimulus, file size sweep and verdict
`timescale 1ns / 1ps
module tb_ymodem_data_frame_receiver;
  import ydfr_pkg::*;
  import ydfr_tb_pkg::*;

  localparam int unsigned PAGE_BYTES   = 256;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CALM_PHASE   = 1;
  localparam int unsigned CUT_LONG_MAX = 140;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_CMP,
    SHAPE_BAD_CRC,
    SHAPE_EXTRA,
    SHAPE_CUT,
    SHAPE_NOISE,
    SHAPE_ABORT
  } frame_shape_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_beat_t             in_beat   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_beat;
  logic                 cfg_we    = 1'b0;
  logic [OFS_W-1:0]     cfg_wdata = '0;

  int                   mismatches;
  int                   pending;
  int                   payloads_seen;
  int                   frames_ok;
  int                   frames_rejected;

  int unsigned          cycle_count = 0;
  int unsigned          idle_pct    = 30;
  int unsigned          stall_pct   = 30;
  int unsigned          beats_sent  = 0;
  int unsigned          frames_sent = 0;
  int unsigned          size_loads  = 0;
  int unsigned          long_budget = 2;
  logic [OFS_W-1:0]     sweep_sizes[$];

  always #10 clk = ~clk;

  ymodem_data_frame_receiver #(.PAGE_BYTES(PAGE_BYTES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ydfr_frame_checker #(.PAGE_BYTES(PAGE_BYTES)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_beat         (in_beat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_beat        (out_beat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .payloads_seen   (payloads_seen),
    .frames_ok       (frames_ok),
    .frames_rejected (frames_rejected)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays up after the accepting edge so back-to-back beats need no toggle
  task automatic send_beat(input logic kind, input logic [7:0] data, input logic last);
    in_beat_t b;
    b.kind      = kind;
    b.in_byte   = data;
    b.last_byte = last;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending != 0) @(posedge clk);
    // beats that cause no result may still sit in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_file_size(input logic [OFS_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_loads++;
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++)
      send_beat(KIND_BYTE, bytes[i], i == bytes.size() - 1);
  endtask

  task automatic send_frame(input frame_shape_t shape, input logic long_hdr);
    logic [7:0]  fb[$];
    logic [7:0]  hdr;
    logic [7:0]  blk;
    logic [7:0]  d;
    logic [15:0] acc;
    int unsigned plen;
    int unsigned cut;
    frames_sent++;
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
      send_bytes(fb);
      return;
    end
    if (long_hdr) begin
      do hdr = 8'($urandom); while (hdr == HDR_SHORT);
    end else begin
      hdr = HDR_SHORT;
    end
    plen = long_hdr ? LONG_LEN : SHORT_LEN;
    blk  = 8'($urandom);
    fb.push_back(hdr);
    fb.push_back(blk);
    if (shape == SHAPE_BAD_CMP) fb.push_back(~blk ^ (8'h01 << $urandom_range(7)));
    else fb.push_back(~blk);
    acc = CRC_INIT;
    for (int i = 0; i < plen; i++) begin
      d = 8'($urandom);
      fb.push_back(d);
      acc = crc16_next(acc, d);
    end
    if (shape == SHAPE_BAD_CRC) acc = acc ^ (16'h0001 << $urandom_range(15));
    fb.push_back(acc[15:8]);
    fb.push_back(acc[7:0]);
    if (shape == SHAPE_EXTRA) begin
      repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
    end
    if (shape == SHAPE_CUT) begin
      // long frames are cut early, to at most CUT_LONG_MAX bytes
      cut = $urandom_range(1, long_hdr ? CUT_LONG_MAX : fb.size() - 1);
      while (fb.size() > cut) void'(fb.pop_back());
    end
    if (shape == SHAPE_ABORT) begin
      // new transfer lands before the end of the frame, possibly before its first byte
      cut = $urandom_range(0, long_hdr ? CUT_LONG_MAX : fb.size() - 1);
      for (int i = 0; i < cut; i++) send_beat(KIND_BYTE, fb[i], 1'b0);
      send_beat(KIND_NEW, 8'($urandom), 1'($urandom));
      return;
    end
    send_bytes(fb);
  endtask

  task automatic send_random_frame();
    int unsigned  pick;
    frame_shape_t shape;
    logic         long_hdr;
    pick = $urandom_range(99);
    if (pick < 50) shape = SHAPE_GOOD;
    else if (pick < 60) shape = SHAPE_BAD_CMP;
    else if (pick < 68) shape = SHAPE_BAD_CRC;
    else if (pick < 76) shape = SHAPE_EXTRA;
    else if (pick < 86) shape = SHAPE_CUT;
    else if (pick < 93) shape = SHAPE_NOISE;
    else shape = SHAPE_ABORT;
    long_hdr = 1'b0;
    if (shape == SHAPE_CUT && long_budget > 0 && $urandom_range(3) == 0) begin
      long_hdr = 1'b1;
      long_budget--;
    end
    send_frame(shape, long_hdr);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_file_size(24'd300);
    // new transfer ignores its byte and last flag
    send_beat(KIND_NEW, 8'hFF, 1'b1);
    // frames that end at the header, the block number and the complement
    send_bytes('{HDR_SHORT});
    send_bytes('{8'h00, 8'h5A});
    send_bytes('{8'hFF, 8'h00, 8'hFF});
    // flagged byte is itself payload: it gives no payload beat, only the verdict
    send_bytes('{HDR_SHORT, 8'h07, 8'hF8, 8'hAA, 8'h55});
    send_beat(KIND_NEW, 8'h00, 1'b0);
    send_frame(SHAPE_GOOD, 1'b0);

    sweep_sizes = '{24'd1, 24'hFF_FFFF};
    sweep_sizes.push_back(OFS_W'($urandom_range(0, 1000)));
    foreach (sweep_sizes[k]) begin
      load_file_size(sweep_sizes[k]);
      idle_pct  = (k == CALM_PHASE) ? 0 : 30;
      stall_pct = (k == CALM_PHASE) ? 0 : 30;
      if (k == 0 || $urandom_range(3) != 0) send_beat(KIND_NEW, 8'($urandom), 1'($urandom));
      if (sweep_sizes[k] == 24'hFF_FFFF) send_frame(SHAPE_CUT, 1'b1);
      send_random_frame();
    end
    settle();

    $display("covered %0d beats in %0d frames across %0d file size settings",
             beats_sent, frames_sent, size_loads);
    $display("saw %0d payload beats, %0d frames accepted, %0d frames rejected",
             payloads_seen, frames_ok, frames_rejected);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
